// ===== rtl/core/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation block.
// Used by every module in rtl/core; depends on nothing else.
package bsc_pkg;

	// Datapath widths.
	localparam int DW         = 64;  // wrapping pressure arithmetic
	localparam int ADC_W      = 20;  // raw conversion results
	localparam int TEMP_W     = 18;  // returned temperature
	localparam int PRES_W     = 32;  // returned pressure
	localparam int COEF_W     = 16;  // one calibration coefficient
	localparam int CFG_W      = 48;  // one configuration register
	localparam int FINE_W     = 25;  // fine temperature
	localparam int V1_W       = 26;  // fine temperature minus offset
	localparam int DEN_W      = 31;  // pressure divisor magnitude
	localparam int DIV_STEPS  = DW;  // one quotient bit per divider stage

	// Formula constants.
	localparam int FINE_OFFSET = 128000;
	localparam int P_FULL      = 1048576;
	localparam int P_SCALE     = 3125;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} reg_idx_t;

	// Calibration coefficients, decoded from the configuration registers.
	typedef struct packed {
		logic        [COEF_W-1:0] t1;
		logic signed [COEF_W-1:0] t2;
		logic signed [COEF_W-1:0] t3;
		logic        [COEF_W-1:0] p1;
		logic signed [COEF_W-1:0] p2;
		logic signed [COEF_W-1:0] p3;
		logic signed [COEF_W-1:0] p4;
		logic signed [COEF_W-1:0] p5;
		logic signed [COEF_W-1:0] p6;
		logic signed [COEF_W-1:0] p7;
		logic signed [COEF_W-1:0] p8;
		logic signed [COEF_W-1:0] p9;
	} coef_t;

	// Control that travels with every word down the pipeline.
	typedef struct packed {
		logic              vld;
		logic              zero;   // pressure divisor was zero
		logic [TEMP_W-1:0] temp;   // finished temperature result
	} ctl_t;

endpackage

// ===== rtl/core/bsc_temp.sv =====
// Temperature compensation stages: raw temperature to fine temperature and
// temperature in hundredths of a degree. Depends on bsc_pkg.
module bsc_temp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  bsc_pkg::coef_t                  coef,
	input  logic                            vld_in,
	input  logic [bsc_pkg::ADC_W-1:0]       adc_t,
	input  logic [bsc_pkg::ADC_W-1:0]       adc_p,
	output bsc_pkg::ctl_t                   ctl_out,
	output logic signed [bsc_pkg::V1_W-1:0] v1_out,
	output logic [bsc_pkg::ADC_W-1:0]       adc_p_out
);

	logic                          vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [33:0]            prod_a_s1;
	logic [31:0]                   dsq_s1;
	logic signed [22:0]            a_s2;
	logic signed [36:0]            bp_s2;
	logic signed [bsc_pkg::FINE_W-1:0] fine_s3;
	logic [bsc_pkg::TEMP_W-1:0]    temp_s4;
	logic signed [bsc_pkg::V1_W-1:0] v1_s4;
	logic [bsc_pkg::ADC_W-1:0]     adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4;

	logic signed [17:0]            xdiff;
	logic signed [16:0]            dd;
	logic signed [33:0]            dd_sq;
	logic signed [bsc_pkg::FINE_W-1:0] fine_d;
	logic signed [27:0]            t5;

	assign xdiff  = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
	assign dd     = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, coef.t1});
	assign dd_sq  = 34'(dd) * 34'(dd);
	assign fine_d = bsc_pkg::FINE_W'(a_s2) + bsc_pkg::FINE_W'(bp_s2 >>> 14);
	assign t5     = 28'(fine_s3) * 28'sd5 + 28'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= 34'(xdiff) * 34'(coef.t2);
			dsq_s1    <= dd_sq[31:0];
			adc_p_s1  <= adc_p;
			a_s2      <= prod_a_s1[33:11];
			bp_s2     <= 37'($signed({1'b0, dsq_s1[31:12]})) * 37'(coef.t3);
			adc_p_s2  <= adc_p_s1;
			fine_s3   <= fine_d;
			adc_p_s3  <= adc_p_s2;
			temp_s4   <= t5[25:8];
			v1_s4     <= bsc_pkg::V1_W'(fine_s3) - bsc_pkg::V1_W'(bsc_pkg::FINE_OFFSET);
			adc_p_s4  <= adc_p_s3;
		end
	end

	assign ctl_out.vld  = vld_s4;
	assign ctl_out.zero = 1'b0;
	assign ctl_out.temp = temp_s4;
	assign v1_out       = v1_s4;
	assign adc_p_out    = adc_p_s4;

endmodule

// ===== rtl/core/bsc_pre.sv =====
// Pressure stages ahead of the divider: builds the 64-bit dividend and the
// divisor and splits them into sign and magnitude. Depends on bsc_pkg.
module bsc_pre (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  bsc_pkg::coef_t                  coef,
	input  bsc_pkg::ctl_t                   ctl_in,
	input  logic signed [bsc_pkg::V1_W-1:0] v1,
	input  logic [bsc_pkg::ADC_W-1:0]       adc_p,
	output bsc_pkg::ctl_t                   ctl_out,
	output logic [bsc_pkg::DW-1:0]          num_out,
	output logic [bsc_pkg::DEN_W-1:0]       den_out,
	output logic                            neg_out
);

	localparam int DW = bsc_pkg::DW;

	bsc_pkg::ctl_t            ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [51:0]       sq_s1;
	logic signed [41:0]       v1p5_s1, v1p2_s1, v1p5_s2, v1p2_s2;
	logic signed [DW-1:0]     m6_s2, m3_s2, v2_s3, v1b_s3;
	logic [DW-1:0]            w_s4, nn_s4, m1_s5, nd_s5, num_s6;
	logic [bsc_pkg::DEN_W-1:0] den_s6;
	logic                     neg_s6;
	logic [bsc_pkg::ADC_W-1:0] adc_p_s1, adc_p_s2, adc_p_s3;

	logic [20:0]              pp;
	logic [bsc_pkg::DEN_W-1:0] den_raw;
	logic                     den_zero;

	assign pp       = 21'(bsc_pkg::P_FULL) - {1'b0, adc_p_s3};
	assign den_raw  = m1_s5[DW-1:33];
	assign den_zero = (den_raw == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= '{vld: ctl_s5.vld, zero: den_zero, temp: ctl_s5.temp};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1    <= 52'(v1) * 52'(v1);
			v1p5_s1  <= 42'(v1) * 42'(coef.p5);
			v1p2_s1  <= 42'(v1) * 42'(coef.p2);
			adc_p_s1 <= adc_p;

			m6_s2    <= 64'(sq_s1) * 64'(coef.p6);
			m3_s2    <= 64'(sq_s1) * 64'(coef.p3);
			v1p5_s2  <= v1p5_s1;
			v1p2_s2  <= v1p2_s1;
			adc_p_s2 <= adc_p_s1;

			v2_s3    <= m6_s2 + (64'(v1p5_s2) <<< 17) + (64'(coef.p4) <<< 35);
			v1b_s3   <= (m3_s2 >>> 8) + (64'(v1p2_s2) <<< 12);
			adc_p_s3 <= adc_p_s2;

			w_s4     <= v1b_s3 + (64'd1 << 47);
			nn_s4    <= {12'd0, pp, 31'd0} - v2_s3;

			m1_s5    <= w_s4 * {48'd0, coef.p1};
			nd_s5    <= nn_s4 * 64'(bsc_pkg::P_SCALE);

			num_s6   <= nd_s5[DW-1] ? (~nd_s5 + 64'd1) : nd_s5;
			den_s6   <= den_raw[bsc_pkg::DEN_W-1] ? (~den_raw + 1'b1) : den_raw;
			neg_s6   <= nd_s5[DW-1] ^ den_raw[bsc_pkg::DEN_W-1];
		end
	end

	assign ctl_out = ctl_s6;
	assign num_out = num_s6;
	assign den_out = den_s6;
	assign neg_out = neg_s6;

endmodule

// ===== rtl/core/bsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned
// magnitudes with the quotient sign carried alongside. Depends on bsc_pkg.
module bsc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  bsc_pkg::ctl_t             ctl_in,
	input  logic [bsc_pkg::DW-1:0]    num,
	input  logic [bsc_pkg::DEN_W-1:0] den,
	input  logic                      neg,
	output bsc_pkg::ctl_t             ctl_out,
	output logic [bsc_pkg::DW-1:0]    quo,
	output logic                      neg_out
);

	localparam int DW    = bsc_pkg::DW;
	localparam int DEN_W = bsc_pkg::DEN_W;
	localparam int N     = bsc_pkg::DIV_STEPS;

	bsc_pkg::ctl_t    ctl_s [N];
	logic [DEN_W-1:0] rem_s [N];
	logic [DW-1:0]    quo_s [N];
	logic [DEN_W-1:0] den_s [N];
	logic             neg_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		bsc_pkg::ctl_t    ctl_i;
		logic [DEN_W-1:0] rem_i;
		logic [DW-1:0]    quo_i;
		logic [DEN_W-1:0] den_i;
		logic             neg_i;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign ctl_i = ctl_in;
			assign rem_i = '0;
			assign quo_i = num;
			assign den_i = den;
			assign neg_i = neg;
		end else begin : g_next
			assign ctl_i = ctl_s[k-1];
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign den_i = den_s[k-1];
			assign neg_i = neg_s[k-1];
		end

		// Shift the next dividend bit into the remainder and try a subtract.
		assign trial = {rem_i, quo_i[DW-1]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[k] <= {quo_i[DW-2:0], ge};
				den_s[k] <= den_i;
				neg_s[k] <= neg_i;
			end
		end
	end

	assign ctl_out = ctl_s[N-1];
	assign quo     = quo_s[N-1];
	assign neg_out = neg_s[N-1];

endmodule

// ===== rtl/core/bsc_post.sv =====
// Pressure stages after the divider: second-order corrections and the final
// Q24.8 result, held in the output register. Depends on bsc_pkg.
module bsc_post (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  bsc_pkg::coef_t               coef,
	input  bsc_pkg::ctl_t                ctl_in,
	input  logic [bsc_pkg::DW-1:0]       quo,
	input  logic                         neg,
	output bsc_pkg::ctl_t                ctl_out,
	output logic [bsc_pkg::PRES_W-1:0]   pres
);

	localparam int DW = bsc_pkg::DW;

	bsc_pkg::ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic signed [DW-1:0]         q_s1, q_s2, q_s3, q_s4;
	logic [DW-1:0]                ll_s2, pss_s3;
	logic [31:0]                  hl_s2;
	logic signed [DW-1:0]         c2m_s2, c2_s3, c2_s4, c1m_s4;
	logic [bsc_pkg::PRES_W-1:0]   pres_s5;

	logic signed [DW-1:0]         ps;
	logic signed [DW-1:0]         sum;
	logic [bsc_pkg::PRES_W-1:0]   pres_d;

	assign ps     = q_s1 >>> 13;
	assign sum    = q_s4 + (c1m_s4 >>> 25) + c2_s4;
	assign pres_d = sum[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= neg ? $signed(~quo + 64'd1) : $signed(quo);

			// Square of ps modulo 2^64 from 32-bit halves.
			ll_s2  <= {32'd0, ps[31:0]} * {32'd0, ps[31:0]};
			hl_s2  <= ps[63:32] * ps[31:0];
			c2m_s2 <= q_s1 * 64'(coef.p8);
			q_s2   <= q_s1;

			pss_s3 <= ll_s2 + {hl_s2[30:0], 1'b0, 32'd0};
			c2_s3  <= c2m_s2 >>> 19;
			q_s3   <= q_s2;

			c1m_s4 <= $signed(pss_s3) * 64'(coef.p9);
			c2_s4  <= c2_s3;
			q_s4   <= q_s3;

			pres_s5 <= ctl_s4.zero ? '0 : pres_d;
		end
	end

	assign ctl_out = ctl_s5;
	assign pres    = pres_s5;

endmodule

// ===== rtl/core/baro_sensor_compensation_top.sv =====
// Barometric sensor compensation, top level: configuration registers and the
// pipeline of bsc_temp, bsc_pre, bsc_div and bsc_post. Depends on bsc_pkg.
//
// Each input word carries one raw 20-bit temperature and one raw 20-bit
// pressure reading and yields exactly one output word with the temperature in
// 0.01 degC (18 bits, signed) and the pressure in Pa as Q24.8 (low 32 bits,
// signed; zero when the pressure divisor comes out zero). The block takes one
// word per clock unless the output stalls; it has 4 temperature stages,
// 6 stages building dividend and divisor, 64 divider stages (one quotient bit
// each, which sets the depth) and 5 correction stages ending in the output
// register. The whole pipeline advances together whenever the output register
// is empty or its word is being taken, so a stall on the output holds every
// stage and no word is lost or repeated. The calibration coefficients are
// written through the configuration channel, which is always ready; write
// them only while no words are in flight. All four registers reset to zero.
module baro_sensor_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [19:0] raw_temperature, [39:20] raw_pressure
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // [17:0] temperature_centi, [49:18] pressure_q24_8
);

	logic [bsc_pkg::CFG_W-1:0] temp_coeffs_q;
	logic [bsc_pkg::CFG_W-1:0] press_a_q;
	logic [bsc_pkg::CFG_W-1:0] press_b_q;
	logic [bsc_pkg::CFG_W-1:0] press_c_q;
	bsc_pkg::coef_t            coef;

	logic                            adv;
	bsc_pkg::ctl_t                   temp_ctl, pre_ctl, div_ctl, post_ctl;
	logic signed [bsc_pkg::V1_W-1:0] v1;
	logic [bsc_pkg::ADC_W-1:0]       adc_p;
	logic [bsc_pkg::DW-1:0]          num;
	logic [bsc_pkg::DEN_W-1:0]       den;
	logic                            neg_pre;
	logic [bsc_pkg::DW-1:0]          quo;
	logic                            neg_div;
	logic [bsc_pkg::PRES_W-1:0]      pres;

	// Configuration writes are taken in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_c_q     <= '0;
		end else if (cfg_valid) begin
			unique case (bsc_pkg::reg_idx_t'(cfg_index))
				bsc_pkg::REG_TEMP:    temp_coeffs_q <= cfg_data;
				bsc_pkg::REG_PRESS_A: press_a_q     <= cfg_data;
				bsc_pkg::REG_PRESS_B: press_b_q     <= cfg_data;
				bsc_pkg::REG_PRESS_C: press_c_q     <= cfg_data;
			endcase
		end
	end

	// Split the registers into the twelve coefficients.
	assign coef.t1 = temp_coeffs_q[15:0];
	assign coef.t2 = $signed(temp_coeffs_q[31:16]);
	assign coef.t3 = $signed(temp_coeffs_q[47:32]);
	assign coef.p1 = press_a_q[15:0];
	assign coef.p2 = $signed(press_a_q[31:16]);
	assign coef.p3 = $signed(press_a_q[47:32]);
	assign coef.p4 = $signed(press_b_q[15:0]);
	assign coef.p5 = $signed(press_b_q[31:16]);
	assign coef.p6 = $signed(press_b_q[47:32]);
	assign coef.p7 = $signed(press_c_q[15:0]);
	assign coef.p8 = $signed(press_c_q[31:16]);
	assign coef.p9 = $signed(press_c_q[47:32]);

	// The pipeline moves as one whenever the output register can change.
	assign adv      = !post_ctl.vld || m_tready;
	assign s_tready = adv;

	bsc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.coef      (coef),
		.vld_in    (s_tvalid),
		.adc_t     (s_tdata[19:0]),
		.adc_p     (s_tdata[39:20]),
		.ctl_out   (temp_ctl),
		.v1_out    (v1),
		.adc_p_out (adc_p)
	);

	bsc_pre u_pre (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.coef    (coef),
		.ctl_in  (temp_ctl),
		.v1      (v1),
		.adc_p   (adc_p),
		.ctl_out (pre_ctl),
		.num_out (num),
		.den_out (den),
		.neg_out (neg_pre)
	);

	bsc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_in  (pre_ctl),
		.num     (num),
		.den     (den),
		.neg     (neg_pre),
		.ctl_out (div_ctl),
		.quo     (quo),
		.neg_out (neg_div)
	);

	bsc_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.coef    (coef),
		.ctl_in  (div_ctl),
		.quo     (quo),
		.neg     (neg_div),
		.ctl_out (post_ctl),
		.pres    (pres)
	);

	assign m_tvalid = post_ctl.vld;
	assign m_tdata  = {6'd0, pres, post_ctl.temp};

endmodule
